// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== rtl/core/hbp_pkg.sv =====
package hbp_pkg;

  localparam int unsigned IDX_W     = 12;
  localparam int unsigned TBL_DEPTH = 1 << IDX_W;
  localparam int unsigned CTR_W     = 2;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned PC_W      = 32;
  localparam int unsigned TOTAL_W   = 32;

  typedef enum logic [2:0] {
    CFG_KIND      = 3'd0,
    CFG_BIM_BITS  = 3'd1,
    CFG_GSH_BITS  = 3'd2,
    CFG_HIST_BITS = 3'd3,
    CFG_CHS_BITS  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_BIMODAL = 2'd0,
    KIND_GSHARE  = 2'd1,
    KIND_HYBRID  = 2'd2
  } kind_e;

  localparam logic [CTR_W-1:0] CTR_MIN     = 2'd0;
  localparam logic [CTR_W-1:0] CTR_WEAK_NT = 2'd1;
  localparam logic [CTR_W-1:0] CTR_WEAK_T  = 2'd2;
  localparam logic [CTR_W-1:0] CTR_MAX     = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CTR_W-1:0] ctr_t;

  typedef struct packed {
    logic [PC_W-1:0] branch_pc;
    logic            actual_taken;
  } hbp_in_t;

  typedef struct packed {
    logic               predicted_taken;
    logic               mispredicted;
    logic               used_gshare;
    logic [TOTAL_W-1:0] prediction_total;
    logic [TOTAL_W-1:0] miss_total;
  } hbp_out_t;

  // forwarding of the write-back that lands in the same cycle as a table read
  typedef struct packed {
    logic bim_hit;
    ctr_t bim_ctr;
    logic gsh_hit;
    ctr_t gsh_ctr;
    logic chs_hit;
    ctr_t chs_ctr;
  } fwd_t;

  function automatic logic [CFG_W-1:0] clamp_bits(logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if ({{(32-CFG_W){1'b0}}, v} > IDX_W) begin
      r = CFG_W'(IDX_W);
    end
    return r;
  endfunction

  function automatic idx_t low_mask(logic [CFG_W-1:0] n);
    idx_t m;
    m = '0;
    for (int i = 0; i < int'(IDX_W); i++) begin
      m[i] = (i < int'(n));
    end
    return m;
  endfunction

  function automatic ctr_t ctr_train(ctr_t c, logic up);
    ctr_t r;
    r = c;
    if (up) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hybrid_branch_predictor_top.sv =====
// accept registers the branch and its table reads, then result_o and done_o are registered
// throughput: one branch per clock while busy is low; each counter table is read
//   (registered) at accept and written back on return, with forwarding between neighbors
// reset: busy stays high while all three tables are cleared one entry a cycle;
//   configuration writes are taken during that time. results cannot be stalled
`include "assert_macros.svh"

module hybrid_branch_predictor_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  hbp_pkg::hbp_in_t               branch_i,
  output logic                           done_o,
  output hbp_pkg::hbp_out_t              result_o,
  input  logic                           cfg_we_i,
  input  hbp_pkg::cfg_idx_e              cfg_idx_i,
  input  logic [hbp_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import hbp_pkg::*;

  // configuration
  logic [1:0]       kind_q;
  logic [CFG_W-1:0] bim_bits_q, gsh_bits_q, hist_bits_q, chs_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= KIND_BIMODAL;
      bim_bits_q  <= CFG_W'(12);
      gsh_bits_q  <= CFG_W'(12);
      hist_bits_q <= CFG_W'(8);
      chs_bits_q  <= CFG_W'(12);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KIND:      kind_q      <= cfg_wdata_i[1:0];
        CFG_BIM_BITS:  bim_bits_q  <= cfg_wdata_i;
        CFG_GSH_BITS:  gsh_bits_q  <= cfg_wdata_i;
        CFG_HIST_BITS: hist_bits_q <= cfg_wdata_i;
        CFG_CHS_BITS:  chs_bits_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0] b_eff, m_eff, k_eff, h_eff;
  logic             hist_on;

  assign b_eff   = clamp_bits(bim_bits_q);
  assign m_eff   = clamp_bits(gsh_bits_q);
  assign k_eff   = clamp_bits(chs_bits_q);
  assign h_eff   = (hist_bits_q > m_eff) ? m_eff : hist_bits_q;
  assign hist_on = (kind_q == KIND_GSHARE) || (kind_q == KIND_HYBRID);

  // table clearing after reset
  logic clearing_q;
  idx_t clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == '1) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign busy = clearing_q;

  logic accept;
  assign accept = start && !busy;

  // index forming at accept
  idx_t hist_q, hist_d, hist_use, hist_next;
  idx_t pc_idx, rd_bi, rd_gi, rd_ci;
  logic [CFG_W-1:0] gsh_shift;

  assign pc_idx    = idx_t'(branch_i.branch_pc[IDX_W+1:2]);
  assign hist_use  = hist_q & low_mask(h_eff);
  assign gsh_shift = m_eff - h_eff;
  assign rd_bi     = pc_idx & low_mask(b_eff);
  assign rd_gi     = (pc_idx & low_mask(m_eff)) ^ (hist_use << gsh_shift);
  assign rd_ci     = pc_idx & low_mask(k_eff);

  // the new history needs only the outcome, so it moves at accept
  assign hist_next = (h_eff == '0) ? '0 :
                     ((hist_use >> 1) | (idx_t'(branch_i.actual_taken) << (h_eff - 4'd1)));

  always_comb begin
    hist_d = hist_q;
    if (accept && hist_on) begin
      hist_d = hist_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else begin
      hist_q <= hist_d;
    end
  end

  // stage 1: counters are back from the tables
  logic s1_valid_q;
  idx_t s1_bi_q, s1_gi_q, s1_ci_q;
  logic s1_taken_q;
  fwd_t fwd_q, fwd_d;

  ctr_t bim_rd, gsh_rd, chs_rd;
  ctr_t bim_ctr, gsh_ctr, chs_ctr;
  ctr_t bim_new, gsh_new, chs_new;
  logic b_pred, g_pred, use_g, pred, miss;
  logic bim_we, gsh_we, chs_we;

  assign bim_ctr = fwd_q.bim_hit ? fwd_q.bim_ctr : bim_rd;
  assign gsh_ctr = fwd_q.gsh_hit ? fwd_q.gsh_ctr : gsh_rd;
  assign chs_ctr = fwd_q.chs_hit ? fwd_q.chs_ctr : chs_rd;

  assign b_pred = bim_ctr[CTR_W-1];
  assign g_pred = gsh_ctr[CTR_W-1];

  always_comb begin
    unique case (kind_q)
      KIND_GSHARE: use_g = 1'b1;
      KIND_HYBRID: use_g = chs_ctr[CTR_W-1];
      default:     use_g = 1'b0;
    endcase
  end

  assign pred = use_g ? g_pred : b_pred;
  assign miss = pred ^ s1_taken_q;

  assign gsh_we = s1_valid_q && use_g;
  assign bim_we = s1_valid_q && !use_g;
  assign chs_we = s1_valid_q && (kind_q == KIND_HYBRID) && (g_pred != b_pred);

  assign bim_new = ctr_train(bim_ctr, s1_taken_q);
  assign gsh_new = ctr_train(gsh_ctr, s1_taken_q);
  assign chs_new = ctr_train(chs_ctr, g_pred == s1_taken_q);

  always_comb begin
    fwd_d.bim_hit = bim_we && (s1_bi_q == rd_bi);
    fwd_d.bim_ctr = bim_new;
    fwd_d.gsh_hit = gsh_we && (s1_gi_q == rd_gi);
    fwd_d.gsh_ctr = gsh_new;
    fwd_d.chs_hit = chs_we && (s1_ci_q == rd_ci);
    fwd_d.chs_ctr = chs_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_bi_q    <= rd_bi;
    s1_gi_q    <= rd_gi;
    s1_ci_q    <= rd_ci;
    s1_taken_q <= branch_i.actual_taken;
    fwd_q      <= fwd_d;
  end

  // table write ports, taken over by the clearing sweep after reset
  logic bim_wen, gsh_wen, chs_wen;
  idx_t bim_wa, gsh_wa, chs_wa;
  ctr_t bim_wd, gsh_wd, chs_wd;

  assign bim_wen = clearing_q || bim_we;
  assign gsh_wen = clearing_q || gsh_we;
  assign chs_wen = clearing_q || chs_we;
  assign bim_wa  = clearing_q ? clr_cnt_q : s1_bi_q;
  assign gsh_wa  = clearing_q ? clr_cnt_q : s1_gi_q;
  assign chs_wa  = clearing_q ? clr_cnt_q : s1_ci_q;
  assign bim_wd  = clearing_q ? CTR_WEAK_T : bim_new;
  assign gsh_wd  = clearing_q ? CTR_WEAK_T : gsh_new;
  assign chs_wd  = clearing_q ? CTR_WEAK_NT : chs_new;

  hbp_ram #(.Width(CTR_W), .Depth(TBL_DEPTH)) u_bim_ram (
    .clk_i   (clk_i),
    .we_i    (bim_wen),
    .waddr_i (bim_wa),
    .wdata_i (bim_wd),
    .raddr_i (rd_bi),
    .rdata_o (bim_rd)
  );

  hbp_ram #(.Width(CTR_W), .Depth(TBL_DEPTH)) u_gsh_ram (
    .clk_i   (clk_i),
    .we_i    (gsh_wen),
    .waddr_i (gsh_wa),
    .wdata_i (gsh_wd),
    .raddr_i (rd_gi),
    .rdata_o (gsh_rd)
  );

  hbp_ram #(.Width(CTR_W), .Depth(TBL_DEPTH)) u_chs_ram (
    .clk_i   (clk_i),
    .we_i    (chs_wen),
    .waddr_i (chs_wa),
    .wdata_i (chs_wd),
    .raddr_i (rd_ci),
    .rdata_o (chs_rd)
  );

  // running totals and result register
  logic [TOTAL_W-1:0] total_q, total_d, miss_cnt_q, miss_cnt_d;
  logic               done_q;
  hbp_out_t           result_q, result_d;

  always_comb begin
    total_d    = total_q;
    miss_cnt_d = miss_cnt_q;
    if (s1_valid_q) begin
      if (total_q != '1) total_d = total_q + 1'b1;
      if (miss && (miss_cnt_q != '1)) miss_cnt_d = miss_cnt_q + 1'b1;
    end
  end

  always_comb begin
    result_d.predicted_taken  = pred;
    result_d.mispredicted     = miss;
    result_d.used_gshare      = use_g;
    result_d.prediction_total = total_d;
    result_d.miss_total       = miss_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      miss_cnt_q <= '0;
      done_q     <= 1'b0;
    end else begin
      total_q    <= total_d;
      miss_cnt_q <= miss_cnt_d;
      done_q     <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      result_q <= result_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `ASSERT_PROP(a_accept_done, clk_i, rst_ni,
               (start && !busy) |=> ##1 done_o,
               "accepted beat gave no result")
  `ASSERT_PROP(a_miss_match, clk_i, rst_ni,
               done_o |-> (result_o.mispredicted ==
                           (result_o.predicted_taken != $past(branch_i.actual_taken, 2))),
               "miss flag disagrees with outcome")
  `ASSERT_PROP(a_miss_le_total, clk_i, rst_ni,
               done_o |-> (result_o.miss_total <= result_o.prediction_total),
               "miss total above branch total")
  `ASSERT_NEVER(a_no_reclear, clk_i, rst_ni,
                $rose(busy),
                "clearing sweep restarted without reset")

endmodule

// ===== rtl/core/hbp_ram.sv =====
module hbp_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
